>>> hdl/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared constants and the result beat type of the length field deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

  // header layout
  localparam int HEADER_BYTES = 36;
  localparam int PORT_OFFSET  = 0;
  localparam int KIND_OFFSET  = 4;
  localparam int PID_OFFSET   = 6;
  localparam int LEN_OFFSET   = 28;
  localparam int USER_OFFSET  = 32;

  // default payload limit
  localparam int MAX_PAYLOAD_DEF = 512;

  // output field widths
  localparam int POS_W    = 9;
  localparam int PLEN_W   = 10;
  localparam int HDR_CNT_W = $clog2(HEADER_BYTES);

  // one result beat
  typedef struct packed {
    logic [7:0]        byte_value;
    logic              in_payload;
    logic [POS_W-1:0]  position;
    logic              header_done;
    logic              frame_done;
    logic [7:0]        port_number;
    logic [7:0]        frame_kind;
    logic [7:0]        protocol_id;
    logic [31:0]       user_word;
    logic [PLEN_W-1:0] payload_length;
    logic              length_clamped;
  } lfd_result_t;

endpackage

>>> hdl/lfd_parser.sv
// ----------------------------------------------------------------------------
// lfd_parser
// Frame state: header byte capture, length clamp and payload byte counting.
// ----------------------------------------------------------------------------
module lfd_parser import lfd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output lfd_result_t result
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int CNT_W = (LEN_W > HDR_CNT_W) ? LEN_W : HDR_CNT_W;

  // frame state
  logic             in_data;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       port_reg;
  logic [7:0]       kind_reg;
  logic [7:0]       pid_reg;
  logic [31:0]      raw_length;
  logic [31:0]      user_reg;
  logic [LEN_W-1:0] length_reg;
  logic             clamp_flag;

  logic [7:0]       port_next;
  logic [7:0]       kind_next;
  logic [7:0]       pid_next;
  logic [31:0]      raw_next;
  logic [31:0]      user_next;
  logic [LEN_W-1:0] len_next;
  logic             clamp_next;
  logic [CNT_W-1:0] cnt_inc;
  logic             hdr_last;
  logic             data_last;
  logic             frame_end;
  logic             show;

  // header capture
  always_comb begin
    port_next = port_reg;
    kind_next = kind_reg;
    pid_next  = pid_reg;
    raw_next  = raw_length;
    user_next = user_reg;
    if (!in_data) begin
      if (byte_count == CNT_W'(PORT_OFFSET)) port_next = data_byte;
      if (byte_count == CNT_W'(KIND_OFFSET)) kind_next = data_byte;
      if (byte_count == CNT_W'(PID_OFFSET))  pid_next  = data_byte;
      for (int i = 0; i < 4; i++) begin
        if (byte_count == CNT_W'(LEN_OFFSET + i))  raw_next[8*i +: 8]  = data_byte;
        if (byte_count == CNT_W'(USER_OFFSET + i)) user_next[8*i +: 8] = data_byte;
      end
    end
  end

  // length clamp and section ends
  always_comb begin
    clamp_next = raw_next > 32'(MAX_PAYLOAD);
    len_next   = clamp_next ? LEN_W'(MAX_PAYLOAD) : raw_next[LEN_W-1:0];
    cnt_inc    = byte_count + CNT_W'(1);
    hdr_last   = !in_data && (byte_count == CNT_W'(HEADER_BYTES - 1));
    data_last  = in_data && (cnt_inc >= CNT_W'(length_reg));
    frame_end  = hdr_last ? (len_next == '0) : data_last;
    show       = hdr_last || in_data;
  end

  // result beat
  always_comb begin
    result.byte_value     = data_byte;
    result.in_payload     = in_data;
    result.position       = POS_W'(byte_count);
    result.header_done    = hdr_last;
    result.frame_done     = frame_end;
    result.port_number    = show ? port_next : 8'd0;
    result.frame_kind     = show ? kind_next : 8'd0;
    result.protocol_id    = show ? pid_next  : 8'd0;
    result.user_word      = show ? user_next : 32'd0;
    result.payload_length = in_data  ? PLEN_W'(length_reg) :
                            hdr_last ? PLEN_W'(len_next)   : '0;
    result.length_clamped = in_data ? clamp_flag : (hdr_last && clamp_next);
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_data    <= 1'b0;
      byte_count <= '0;
      port_reg   <= '0;
      kind_reg   <= '0;
      pid_reg    <= '0;
      raw_length <= '0;
      user_reg   <= '0;
      length_reg <= '0;
      clamp_flag <= 1'b0;
    end else if (accept) begin
      if (restart || frame_end) begin
        in_data    <= 1'b0;
        byte_count <= '0;
        port_reg   <= '0;
        kind_reg   <= '0;
        pid_reg    <= '0;
        raw_length <= '0;
        user_reg   <= '0;
        length_reg <= '0;
        clamp_flag <= 1'b0;
      end else if (!in_data) begin
        port_reg   <= port_next;
        kind_reg   <= kind_next;
        pid_reg    <= pid_next;
        raw_length <= raw_next;
        user_reg   <= user_next;
        if (hdr_last) begin
          in_data    <= 1'b1;
          byte_count <= '0;
          length_reg <= len_next;
          clamp_flag <= clamp_next;
        end else begin
          byte_count <= cnt_inc;
        end
      end else begin
        byte_count <= cnt_inc;
      end
    end
  end

  // payload phase always has a nonzero length and stays inside it
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_data |-> length_reg != '0)
    else $error("payload phase with zero length");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    in_data |-> byte_count < CNT_W'(length_reg))
    else $error("payload count past length");

  a_hdr_cnt_range: assert property (@(posedge clk) disable iff (rst)
    !in_data |-> byte_count < CNT_W'(HEADER_BYTES))
    else $error("header count past header size");

  a_frame_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (restart || frame_end) |=> !in_data && byte_count == '0)
    else $error("state not cleared at frame end or restart");

endmodule

>>> hdl/lfd_out_stage.sv
// ----------------------------------------------------------------------------
// lfd_out_stage
// Result register with valid/ready; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module lfd_out_stage import lfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  lfd_result_t result_in,
  output logic        can_take,
  output logic        out_valid,
  input  logic        out_ready,
  output lfd_result_t result_out
);

  logic out_valid_next;

  // free when empty or being drained this cycle
  assign can_take       = !out_valid || out_ready;
  assign out_valid_next = load || (out_valid && !out_ready);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

>>> hdl/length_field_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_field_frame_deframer
// Splits a byte stream into 36-byte headers and length-sized payloads.
// ----------------------------------------------------------------------------
// One byte enters per beat and every byte comes out of the result register,
// tagged with its section, its offset and the fields decoded from the header;
// the block takes a byte in every cycle, limited only by the single result
// register, which refills in the same cycle it is drained. The payload
// length (header bytes 28..31, little-endian) is clamped to MAX_PAYLOAD;
// a zero length ends the frame on the last header byte. A beat with restart
// set drops the partial frame and gives no result.
module length_field_frame_deframer import lfd_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        byte_value,
  output logic              in_payload,
  output logic [POS_W-1:0]  position,
  output logic              header_done,
  output logic              frame_done,
  output logic [7:0]        port_number,
  output logic [7:0]        frame_kind,
  output logic [7:0]        protocol_id,
  output logic [31:0]       user_word,
  output logic [PLEN_W-1:0] payload_length,
  output logic              length_clamped
);

  logic        accept;
  logic        can_take;
  lfd_result_t result;
  lfd_result_t result_q;

  assign in_ready = can_take;
  assign accept   = in_valid && can_take;

  // frame state and field decode
  lfd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .restart   (restart),
    .result    (result)
  );

  // result register
  lfd_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && !restart),
    .result_in  (result),
    .can_take   (can_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (result_q)
  );

  // result fields to ports
  assign byte_value     = result_q.byte_value;
  assign in_payload     = result_q.in_payload;
  assign position       = result_q.position;
  assign header_done    = result_q.header_done;
  assign frame_done     = result_q.frame_done;
  assign port_number    = result_q.port_number;
  assign frame_kind     = result_q.frame_kind;
  assign protocol_id    = result_q.protocol_id;
  assign user_word      = result_q.user_word;
  assign payload_length = result_q.payload_length;
  assign length_clamped = result_q.length_clamped;

endmodule
